// ===== hdl/mmng_pkg.sv =====
`default_nettype none
package mmng_pkg;

	localparam int PINK_ROWS  = 8;
	localparam int ROW_W      = $clog2(PINK_ROWS);
	localparam int SUM_W      = 25 + ROW_W;
	localparam int PINK_SHIFT = 3;
	localparam int SAMPLE_W   = 28;
	localparam int CNT_W      = 5;

	localparam logic [31:0] SEED_FALLBACK = 32'h1234_5678;

	localparam logic [1:0] NT_UNIFORM = 2'd0;
	localparam logic [1:0] NT_NORMAL  = 2'd1;
	localparam logic [1:0] NT_PINK    = 2'd2;

	localparam int LOG_STEPS    = 16;
	localparam int SQRT_STEPS   = 19;
	localparam int HORNER_STEPS = 4;

	localparam logic [26:0] TWO_LN2_Q16    = 27'd90852;
	localparam logic [26:0] HALF_ROOT2_Q16 = 27'd46341;

	localparam logic signed [27:0] SIN_C9 = 28'sd2692;
	localparam logic signed [27:0] SIN_C7 = -28'sd78547;
	localparam logic signed [27:0] SIN_C5 = 28'sd1337020;
	localparam logic signed [27:0] SIN_C3 = -28'sd10837479;
	localparam logic signed [27:0] SIN_C1 = 28'sd26353589;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_SEED,
		DP_UNI,
		DP_N_U1,
		DP_N_U2,
		DP_M_SQ,
		DP_W_LOG,
		DP_M_T,
		DP_W_S,
		DP_SQRT,
		DP_M_XX,
		DP_W_Y,
		DP_M_PY,
		DP_W_P,
		DP_M_PX,
		DP_W_SM,
		DP_M_RK,
		DP_W_RK,
		DP_M_RS,
		DP_W_MAG,
		DP_P_INIT,
		DP_P_ROW,
		DP_P_END
	} dp_op_t;

	typedef struct packed {
		dp_op_t             op;
		logic [CNT_W-1:0]   cnt;
	} dp_cmd_t;

	function automatic logic [31:0] xorshift32(input logic [31:0] x);
		logic [31:0] v;
		v = x ^ (x << 13);
		v = v ^ (v >> 17);
		v = v ^ (v << 5);
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/multi_mode_noise_generator_top.sv =====
// Multi-mode noise generator.
// Input channel (in_valid/in_ready, noise_type) takes one request per sample:
// uniform (0, also 3), normal (1) or pink (2). Output channel
// (out_valid/out_ready, noise_sample) returns one 28-bit signed sample, scale 2^24.
// Config channel (cfg_valid/cfg_ready, seed) reloads the xorshift32 state
// (zero seed uses 0x12345678), clears the pink rows and sets the frame counter
// to all ones; it is taken only while no request is in flight.
// Work per request: uniform takes one draw, pink sums PINK_ROWS rows (one row
// per cycle), normal takes two draws, the 16 log squaring steps on the shared
// multiplier, the bit-serial square root, the sine polynomial and the scaling
// products. A request is accepted only once the previous one has finished.
// The sample sits in an output register: a new request is accepted while it
// waits, and a stalled receiver holds the next finished sample in the last
// datapath step until the register frees up.
// Reset: seed state 0x12345678, pink rows zero, frame all ones, output empty.
`default_nettype none
module multi_mode_noise_generator_top import mmng_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            noise_type,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic signed [SAMPLE_W-1:0] noise_sample,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [31:0]           seed
);

	dp_cmd_t cmd;

	mmng_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.noise_type (noise_type),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cmd        (cmd)
	);

	mmng_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.seed   (seed),
		.sample (noise_sample)
	);

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request did not start work");

	a_cfg_no_work: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && !in_valid |=> in_ready)
		else $error("seed write left the block busy");

	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("sample appeared without a request in flight");

endmodule
`default_nettype wire

// ===== hdl/mmng_ctrl.sv =====
`default_nettype none
module mmng_ctrl import mmng_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] noise_type,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	output dp_cmd_t         cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_UNI, S_NU1, S_NU2, S_LMUL, S_LWB, S_TMUL, S_TWB, S_SQRT,
		S_XMUL, S_XWB, S_PMUL, S_PWB, S_QMUL, S_QWB, S_KMUL, S_KWB,
		S_RMUL, S_RWB, S_PINIT, S_PROW, S_PEND
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             slot_free;
	logic             finish;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign finish    = slot_free &&
		(state_q == S_UNI || state_q == S_RWB || state_q == S_PEND);

	always_comb begin
		cmd.cnt = cnt_q;
		unique case (state_q)
			S_IDLE:  cmd.op = (cfg_valid) ? DP_SEED : DP_NOP;
			S_UNI:   cmd.op = slot_free ? DP_UNI : DP_NOP;
			S_NU1:   cmd.op = DP_N_U1;
			S_NU2:   cmd.op = DP_N_U2;
			S_LMUL:  cmd.op = DP_M_SQ;
			S_LWB:   cmd.op = DP_W_LOG;
			S_TMUL:  cmd.op = DP_M_T;
			S_TWB:   cmd.op = DP_W_S;
			S_SQRT:  cmd.op = DP_SQRT;
			S_XMUL:  cmd.op = DP_M_XX;
			S_XWB:   cmd.op = DP_W_Y;
			S_PMUL:  cmd.op = DP_M_PY;
			S_PWB:   cmd.op = DP_W_P;
			S_QMUL:  cmd.op = DP_M_PX;
			S_QWB:   cmd.op = DP_W_SM;
			S_KMUL:  cmd.op = DP_M_RK;
			S_KWB:   cmd.op = DP_W_RK;
			S_RMUL:  cmd.op = DP_M_RS;
			S_RWB:   cmd.op = slot_free ? DP_W_MAG : DP_NOP;
			S_PINIT: cmd.op = DP_P_INIT;
			S_PROW:  cmd.op = DP_P_ROW;
			S_PEND:  cmd.op = slot_free ? DP_P_END : DP_NOP;
			default: cmd.op = DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (in_valid) begin
						priority if (noise_type == NT_NORMAL)
							state_q <= S_NU1;
						else if (noise_type == NT_PINK)
							state_q <= S_PINIT;
						else
							state_q <= S_UNI;
					end
				end
				S_UNI:  if (slot_free) state_q <= S_IDLE;
				S_NU1:  state_q <= S_NU2;
				S_NU2:  state_q <= S_LMUL;
				S_LMUL: state_q <= S_LWB;
				S_LWB: begin
					if (cnt_q == CNT_W'(LOG_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_TMUL;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_LMUL;
					end
				end
				S_TMUL: state_q <= S_TWB;
				S_TWB:  state_q <= S_SQRT;
				S_SQRT: begin
					if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_XMUL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_XMUL: state_q <= S_XWB;
				S_XWB:  state_q <= S_PMUL;
				S_PMUL: state_q <= S_PWB;
				S_PWB: begin
					if (cnt_q == CNT_W'(HORNER_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_QMUL;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_PMUL;
					end
				end
				S_QMUL: state_q <= S_QWB;
				S_QWB:  state_q <= S_KMUL;
				S_KMUL: state_q <= S_KWB;
				S_KWB:  state_q <= S_RMUL;
				S_RMUL: state_q <= S_RWB;
				S_RWB:  if (slot_free) state_q <= S_IDLE;
				S_PINIT: begin
					cnt_q   <= '0;
					state_q <= S_PROW;
				end
				S_PROW: begin
					if (cnt_q == CNT_W'(PINK_ROWS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_PEND;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_PEND:  if (slot_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hdl/mmng_dp.sv =====
`default_nettype none
module mmng_dp import mmng_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dp_cmd_t              cmd,
	input  wire logic [31:0]          seed,
	output logic signed [SAMPLE_W-1:0] sample
);

	logic [31:0]             rng_q;
	logic [PINK_ROWS-1:0]    frame_q;
	logic [PINK_ROWS-1:0]    diff_q;
	logic signed [24:0]      rows_q [PINK_ROWS];
	logic signed [SUM_W-1:0] acc_q;

	logic [23:0]             m_q;
	logic [4:0]              e_q;
	logic [15:0]             frac_q;
	logic [38:0]             rem_q;
	logic [38:0]             root_q;
	logic [38:0]             bit_q;
	logic [1:0]              quad_q;
	logic [24:0]             x_q;
	logic [24:0]             y_q;
	logic signed [27:0]      p_q;
	logic [24:0]             sm_q;
	logic [35:0]             rk_q;
	logic signed [62:0]      prod_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	logic [31:0]             rng_next;
	logic [23:0]             draw;
	logic                    draws;
	logic [23:0]             u1;
	logic [4:0]              u1_e;
	logic [21:0]             t_val;
	logic signed [35:0]      mul_a;
	logic signed [26:0]      mul_b;
	logic                    is_mul;
	logic [ROW_W-1:0]        row;
	logic signed [24:0]      row_val;
	logic [24:0]             mm;
	logic [38:0]             trial;
	logic signed [27:0]      coef;
	logic [27:0]             mag;
	logic signed [SUM_W-1:0] acc_sh;
	logic [PINK_ROWS-1:0]    frame_next;

	assign rng_next   = xorshift32(rng_q);
	assign draw       = rng_next[31:8];
	assign row        = cmd.cnt[ROW_W-1:0];
	assign frame_next = frame_q + 1'b1;
	assign u1         = (draw == 24'd0) ? 24'd1 : draw;
	assign t_val      = 22'(24 << 16) - ({e_q, 16'b0} + {5'b0, frac_q});
	assign mm         = prod_q[47:23];
	assign trial      = root_q + bit_q;
	assign mag        = prod_q[59:32];
	assign acc_sh     = acc_q >>> PINK_SHIFT;
	assign row_val    = diff_q[row] ? (25'({1'b0, draw}) - 25'sd8388608) : rows_q[row];
	assign sample     = sample_q;

	always_comb begin
		u1_e = '0;
		for (int i = 0; i < 24; i++) begin
			if (u1[i])
				u1_e = 5'(i);
		end
	end

	always_comb begin
		unique case (cmd.op)
			DP_UNI, DP_N_U1, DP_N_U2: draws = 1'b1;
			DP_P_ROW:                 draws = diff_q[row];
			default:                  draws = 1'b0;
		endcase
	end

	always_comb begin
		unique case (cmd.cnt[1:0])
			2'd0:    coef = SIN_C7;
			2'd1:    coef = SIN_C5;
			2'd2:    coef = SIN_C3;
			default: coef = SIN_C1;
		endcase
	end

	always_comb begin
		is_mul = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (cmd.op)
			DP_M_SQ: begin
				mul_a = {12'b0, m_q};
				mul_b = {3'b0, m_q};
			end
			DP_M_T: begin
				mul_a = {14'b0, t_val};
				mul_b = TWO_LN2_Q16;
			end
			DP_M_XX: begin
				mul_a = {11'b0, x_q};
				mul_b = {2'b0, x_q};
			end
			DP_M_PY: begin
				mul_a = 36'(p_q);
				mul_b = {2'b0, y_q};
			end
			DP_M_PX: begin
				mul_a = 36'(p_q);
				mul_b = {2'b0, x_q};
			end
			DP_M_RK: begin
				mul_a = {16'b0, root_q[19:0]};
				mul_b = HALF_ROOT2_Q16;
			end
			DP_M_RS: begin
				mul_a = rk_q;
				mul_b = {2'b0, sm_q};
			end
			default: is_mul = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (is_mul)
			prod_q <= mul_a * mul_b;

		unique case (cmd.op)
			DP_UNI:
				sample_q <= SAMPLE_W'({3'b0, draw, 1'b0}) - SAMPLE_W'(28'h100_0000);
			DP_N_U1: begin
				e_q    <= u1_e;
				m_q    <= u1 << (5'd23 - u1_e);
				frac_q <= '0;
			end
			DP_N_U2: begin
				quad_q <= draw[23:22];
				x_q    <= draw[22] ? {(23'h40_0000 - {1'b0, draw[21:0]}), 2'b00}
				                   : {1'b0, draw[21:0], 2'b00};
			end
			DP_W_LOG: begin
				if (mm[24]) begin
					m_q    <= mm[24:1];
					frac_q <= {frac_q[14:0], 1'b1};
				end else begin
					m_q    <= mm[23:0];
					frac_q <= {frac_q[14:0], 1'b0};
				end
			end
			DP_W_S: begin
				rem_q  <= {1'b0, prod_q[37:16], 16'b0};
				root_q <= '0;
				bit_q  <= 39'(1) << 36;
			end
			DP_SQRT: begin
				if (rem_q >= trial) begin
					rem_q  <= rem_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			DP_W_Y: begin
				y_q <= prod_q[48:24];
				p_q <= SIN_C9;
			end
			DP_W_P:
				p_q <= coef + prod_q[51:24];
			DP_W_SM:
				sm_q <= prod_q[62] ? 25'd0 : prod_q[48:24];
			DP_W_RK:
				rk_q <= prod_q[35:0];
			DP_W_MAG:
				sample_q <= quad_q[1] ? -mag : mag;
			DP_P_END:
				sample_q <= SAMPLE_W'(acc_sh);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rng_q   <= SEED_FALLBACK;
			frame_q <= '1;
			diff_q  <= '0;
			acc_q   <= '0;
			for (int i = 0; i < PINK_ROWS; i++)
				rows_q[i] <= '0;
		end else begin
			if (draws)
				rng_q <= rng_next;
			unique case (cmd.op)
				DP_SEED: begin
					rng_q   <= (seed != 32'd0) ? seed : SEED_FALLBACK;
					frame_q <= '1;
					for (int i = 0; i < PINK_ROWS; i++)
						rows_q[i] <= '0;
				end
				DP_P_INIT: begin
					frame_q <= frame_next;
					diff_q  <= frame_q ^ frame_next;
					acc_q   <= '0;
				end
				DP_P_ROW: begin
					rows_q[row] <= row_val;
					acc_q       <= acc_q + SUM_W'(row_val);
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sim/multi_mode_noise_generator_top_tb.sv =====
`default_nettype none
module multi_mode_noise_generator_top_tb;
	import mmng_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] noise_type = NT_UNIFORM;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] noise_sample;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [31:0] seed = '0;

	localparam logic [1:0] NT_SPARE = 2'd3;

	multi_mode_noise_generator_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .noise_type(noise_type),
		.out_valid(out_valid), .out_ready(out_ready), .noise_sample(noise_sample),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .seed(seed)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [31:0] gen_state;
	logic [PINK_ROWS-1:0] frame_cnt;
	logic signed [24:0] row_val [PINK_ROWS];

	logic [SAMPLE_W-1:0] sample_q [$];
	int errors = 0;
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;

	function automatic logic [23:0] next_draw();
		logic [31:0] x;
		x = gen_state;
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		gen_state = x;
		return x[31:8];
	endfunction

	function automatic longint fshift(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint unsigned neg2ln(logic [23:0] u);
		int e;
		longint unsigned m;
		longint unsigned t;
		logic [31:0] frac;
		e = 23;
		frac = 0;
		while (e > 0 && u[e] == 1'b0)
			e--;
		m = longint'(u) << (23 - e);
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 23;
			frac = frac << 1;
			if (m >= (64'd1 << 24)) begin
				m = m >> 1;
				frac[0] = 1'b1;
			end
		end
		t = (64'd24 << 16) - ((longint'(e) << 16) + frac);
		t = t & 64'hFFFF_FFFF;
		return (t * 90852) >> 16;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint quarter_sine(longint x);
		longint y, p;
		y = (x * x) >>> 24;
		p = 2692;
		p = -78547 + fshift(p * y, 24);
		p = 1337020 + fshift(p * y, 24);
		p = -10837479 + fshift(p * y, 24);
		p = 26353589 + fshift(p * y, 24);
		p = fshift(p * x, 24);
		return (p < 0) ? 0 : p;
	endfunction

	function automatic longint normal_value();
		logic [23:0] u1, u2;
		logic [1:0] quad;
		longint unsigned r, sm, mag;
		longint x;
		u1 = next_draw();
		if (u1 == 0)
			u1 = 1;
		u2 = next_draw();
		r = int_sqrt(neg2ln(u1) << 16);
		quad = u2[23:22];
		x = quad[0] ? (longint'(24'h40_0000 - u2[21:0]) << 2) : (longint'(u2[21:0]) << 2);
		sm = quarter_sine(x);
		mag = (r * sm * 46341) >> 32;
		return quad[1] ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic longint pink_value();
		logic [PINK_ROWS-1:0] nxt, diff;
		longint sum;
		nxt = frame_cnt + 1'b1;
		diff = frame_cnt ^ nxt;
		frame_cnt = nxt;
		sum = 0;
		for (int i = 0; i < PINK_ROWS; i++) begin
			if (diff[i])
				row_val[i] = 25'(longint'(next_draw()) - 64'h80_0000);
			sum += row_val[i];
		end
		return fshift(sum, PINK_SHIFT);
	endfunction

	function automatic logic [SAMPLE_W-1:0] predict_sample(logic [1:0] kind);
		longint v;
		case (kind)
			NT_NORMAL: v = normal_value();
			NT_PINK:   v = pink_value();
			default:   v = 2 * longint'(next_draw()) - (64'd1 << 24);
		endcase
		return v[SAMPLE_W-1:0];
	endfunction

	function automatic void load_seed(logic [31:0] v);
		gen_state = (v != 0) ? v : SEED_FALLBACK;
		frame_cnt = '1;
		for (int i = 0; i < PINK_ROWS; i++)
			row_val[i] = '0;
	endfunction

	task automatic send_request(logic [1:0] kind);
		while (($urandom % 100) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		noise_type <= kind;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sample_q.push_back(predict_sample(kind));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sample_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_seed(logic [31:0] v);
		drain();
		cfg_valid <= 1'b1;
		seed <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		load_seed(v);
	endtask

	task automatic send_random(int n, int pct_normal);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < pct_normal)
				send_request(NT_NORMAL);
			else if (r < pct_normal + 40)
				send_request(NT_PINK);
			else if (r < pct_normal + 45)
				send_request(NT_SPARE);
			else
				send_request(NT_UNIFORM);
		end
	endtask

	task automatic test_directed();
		send_request(NT_UNIFORM);
		send_request(NT_NORMAL);
		send_request(NT_PINK);
		send_request(NT_SPARE);
		write_seed(32'h0);
		send_request(NT_PINK);
		send_request(NT_NORMAL);
		write_seed(32'hFFFF_FFFF);
		send_request(NT_UNIFORM);
		send_request(NT_NORMAL);
		write_seed(32'h0000_0001);
		for (int i = 0; i < 6; i++)
			send_request(NT_NORMAL);
		write_seed(32'h8000_0000);
		for (int i = 0; i < 10; i++)
			send_request(NT_PINK);
	endtask

	task automatic test_no_idle();
		write_seed($urandom);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_random(130, 20);
	endtask

	task automatic test_sender_idle();
		write_seed($urandom);
		send_idle_pct = 64;
		recv_stall_pct = 0;
		send_random(130, 20);
	endtask

	task automatic test_receiver_stall();
		write_seed($urandom);
		send_idle_pct = 0;
		recv_stall_pct = 64;
		send_random(130, 20);
	endtask

	task automatic test_both_idle();
		write_seed($urandom);
		send_idle_pct = 26;
		recv_stall_pct = 26;
		send_random(130, 20);
	endtask

	task automatic test_backpressure();
		drain();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 300;
		send_random(20, 0);
		drain();
		send_random(10, 30);
	endtask

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom % 100) >= recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (sample_q.size() == 0) begin
				errors++;
				$display("unexpected sample %h", noise_sample);
			end else if (noise_sample !== sample_q[0]) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("sample mismatch: expected %h actual %h", sample_q[0], noise_sample);
				void'(sample_q.pop_front());
			end else begin
				void'(sample_q.pop_front());
			end
		end
	end

	initial begin
		load_seed(SEED_FALLBACK);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_backpressure();
		drain();
		if (errors == 0 && sample_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/mmng_pkg.sv
hdl/mmng_ctrl.sv
hdl/mmng_dp.sv
hdl/multi_mode_noise_generator_top.sv
sim/multi_mode_noise_generator_top_tb.sv
